// ===== rtl/core/fees_pkg.sv =====
// Package of the flash EEPROM emulation store: field widths, codes and sequencer states.
// Depends on nothing; every other file of the block imports it.
package fees_pkg;

    localparam int FIELD_W          = 16;
    localparam int REQ_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int WORD_W           = 32;
    localparam int PAGE_SLOTS_DEF   = 256;
    localparam int PAGE_COUNT_DEF   = 2;

    localparam logic [FIELD_W-1:0] ERASED_HALF = 16'hffff;
    localparam logic [WORD_W-1:0]  ERASED_WORD = 32'hffff_ffff;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_READ      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INIT      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE_ALL = 2'd3;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_OP,
        S_RD_RD,
        S_RD_CHK,
        S_WR_RD,
        S_WR_CHK,
        S_ER_PAGE,
        S_ER_SWEEP,
        S_ER_NEXT,
        S_RS_START,
        S_RS_CHK,
        S_RS_SRC_RD,
        S_RS_SRC_CHK,
        S_RS_TGT_RD,
        S_RS_TGT_CHK,
        S_RS_PLACE,
        S_RS_NEXT,
        S_MK_RD,
        S_MK_WR,
        S_RE_SWEEP,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/fees_if.sv =====
// Channel interfaces of the flash EEPROM emulation store: request, response, configuration.
// Depends on fees_pkg for the field widths.
interface fees_req_if
    import fees_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [FIELD_W-1:0]  tag;
    logic [FIELD_W-1:0]  value;

    modport source (output valid, output req_type, output tag, output value, input ready);
    modport sink   (input valid, input req_type, input tag, input value, output ready);
endinterface

interface fees_rsp_if
    import fees_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

interface fees_cfg_if
    import fees_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/flash_eeprom_emulation_store_top.sv =====
// Top level of the flash EEPROM emulation store: sequencer around one flash image memory.
// Depends on fees_pkg and the channel interfaces in fees_if.sv.
//
//   channel | direction | payload                    | transaction
//   req     | in        | req_type, tag, value       | valid && ready
//   rsp     | out       | status, read_data          | valid && ready
//   cfg     | in        | data (current_marker)      | valid && ready
//
// Every memory access sets the address, then uses the registered read data. Finding the current
// page reads the marker slot of each page in turn; a read or a write then scans that page's slots.
// An erase sweeps one slot a cycle; a rescue scans the copied entries for every source slot,
// all through the single memory port.
// After reset a clearing pass writes every word of the memory before the first request.
// A new request is taken while a finished response still waits on a stalled rsp channel.
module flash_eeprom_emulation_store_top
    import fees_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    fees_req_if.sink    req,
    fees_rsp_if.source  rsp,
    fees_cfg_if.sink    cfg
);

    localparam int WORDS  = PAGE_SLOTS * PAGE_COUNT;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int SLOT_W = $clog2(PAGE_SLOTS);
    localparam int FILL_W = $clog2(PAGE_SLOTS + 1);
    localparam int PAGE_W = $clog2(PAGE_COUNT);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PAGE_SLOTS - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WORDS - 1);

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] pg,
                                                  input logic [SLOT_W-1:0] sl);
        addr_of = ADDR_W'(pg) * ADDR_W'(PAGE_SLOTS) + ADDR_W'(sl);
    endfunction

    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_type_reg, req_type_next;
    logic [FIELD_W-1:0]  tag_reg, tag_next;
    logic [FIELD_W-1:0]  value_reg, value_next;
    logic [PAGE_W-1:0]   cur_reg, cur_next;
    logic                found_reg, found_next;
    logic [PAGE_W-1:0]   pg_reg, pg_next;
    logic [PAGE_W-1:0]   tgt_reg, tgt_next;
    logic [PAGE_W-1:0]   mark_pg_reg, mark_pg_next;
    logic                rescue_reg, rescue_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   jslot_reg, jslot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [FIELD_W-1:0]  marker_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FIELD_W-1:0]  res_data_reg, res_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FIELD_W-1:0]  out_data_reg, out_data_next;

    // Flash image memory with one write port and one registered read port.
    logic [WORD_W-1:0]   mem [WORDS];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    logic [WORD_W-1:0]   mem_wd;
    logic [ADDR_W-1:0]   mem_ra;
    logic [WORD_W-1:0]   rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    // Configuration register; it is only written while the block is idle.
    assign cfg.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            marker_reg <= cfg.data;
        end
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        tag_reg        <= tag_next;
        value_reg      <= value_next;
        cur_reg        <= cur_next;
        found_reg      <= found_next;
        pg_reg         <= pg_next;
        tgt_reg        <= tgt_next;
        mark_pg_reg    <= mark_pg_next;
        rescue_reg     <= rescue_next;
        slot_reg       <= slot_next;
        jslot_reg      <= jslot_next;
        fill_reg       <= fill_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_data = out_data_reg;

    // Sequencer: next state, memory accesses and response.
    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        tag_next        = tag_reg;
        value_next      = value_reg;
        cur_next        = cur_reg;
        found_next      = found_reg;
        pg_next         = pg_reg;
        tgt_next        = tgt_reg;
        mark_pg_next    = mark_pg_reg;
        rescue_next     = rescue_reg;
        slot_next       = slot_reg;
        jslot_next      = jslot_reg;
        fill_next       = fill_reg;
        word_next       = word_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = ERASED_WORD;
        mem_ra          = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next   = req.req_type;
                    tag_next        = req.tag;
                    value_next      = req.value;
                    pg_next         = '0;
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    state_next      = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                mem_ra     = addr_of(pg_reg, '0);
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (rdata_reg[FIELD_W-1:0] == marker_reg)
                begin
                    cur_next   = pg_reg;
                    found_next = 1'b1;
                    state_next = S_OP;
                end
                else if (pg_reg == PAGE_LAST)
                begin
                    found_next = 1'b0;
                    state_next = S_OP;
                end
                else
                begin
                    pg_next    = pg_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_OP:
            begin
                pg_next = '0;
                case (req_type_reg)
                    REQ_READ:
                    begin
                        slot_next = SLOT_LAST;
                        if (found_reg)
                        begin
                            state_next = S_RD_RD;
                        end
                        else
                        begin
                            res_status_next = ST_NO_PAGE;
                            state_next      = S_DONE;
                        end
                    end
                    REQ_WRITE:
                    begin
                        slot_next = SLOT_W'(1);
                        if (found_reg)
                        begin
                            state_next = S_WR_RD;
                        end
                        else
                        begin
                            res_status_next = ST_NO_PAGE;
                            state_next      = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_ER_PAGE;
                    end
                endcase
            end
            // Read: newest slot to oldest.
            S_RD_RD:
            begin
                mem_ra     = addr_of(cur_reg, slot_reg);
                state_next = S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (rdata_reg[FIELD_W-1:0] == tag_reg)
                begin
                    res_data_next = rdata_reg[WORD_W-1:FIELD_W];
                    state_next    = S_DONE;
                end
                else if (slot_reg == SLOT_W'(1))
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    slot_next  = slot_reg - 1'b1;
                    state_next = S_RD_RD;
                end
            end
            // Write: append to the first empty slot.
            S_WR_RD:
            begin
                mem_ra     = addr_of(cur_reg, slot_reg);
                state_next = S_WR_CHK;
            end
            S_WR_CHK:
            begin
                if (rdata_reg == ERASED_WORD)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = addr_of(cur_reg, slot_reg);
                    mem_wd     = {value_reg, tag_reg};
                    state_next = S_RS_START;
                end
                else if (slot_reg == SLOT_LAST)
                begin
                    state_next = S_RS_START;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_WR_RD;
                end
            end
            // Page erase loop for initialize and erase all.
            S_ER_PAGE:
            begin
                slot_next = '0;
                if (req_type_reg == REQ_INIT && found_reg && pg_reg == cur_reg)
                begin
                    state_next = S_ER_NEXT;
                end
                else
                begin
                    state_next = S_ER_SWEEP;
                end
            end
            S_ER_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wa    = addr_of(pg_reg, slot_reg);
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = S_ER_NEXT;
                end
            end
            S_ER_NEXT:
            begin
                if (pg_reg == PAGE_LAST)
                begin
                    if (req_type_reg == REQ_ERASE_ALL || !found_reg)
                    begin
                        mark_pg_next = '0;
                        rescue_next  = 1'b0;
                        state_next   = S_MK_RD;
                    end
                    else
                    begin
                        state_next = S_RS_START;
                    end
                end
                else
                begin
                    pg_next    = pg_reg + 1'b1;
                    state_next = S_ER_PAGE;
                end
            end
            // Rescue: only when the last slot of the current page is used.
            S_RS_START:
            begin
                mem_ra     = addr_of(cur_reg, SLOT_LAST);
                state_next = S_RS_CHK;
            end
            S_RS_CHK:
            begin
                if (rdata_reg == ERASED_WORD)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tgt_next   = (cur_reg == PAGE_LAST) ? '0 : cur_reg + 1'b1;
                    fill_next  = FILL_W'(1);
                    slot_next  = SLOT_LAST;
                    state_next = S_RS_SRC_RD;
                end
            end
            S_RS_SRC_RD:
            begin
                mem_ra     = addr_of(cur_reg, slot_reg);
                state_next = S_RS_SRC_CHK;
            end
            S_RS_SRC_CHK:
            begin
                word_next  = rdata_reg;
                jslot_next = SLOT_W'(1);
                if (rdata_reg[FIELD_W-1:0] == ERASED_HALF)
                begin
                    state_next = S_RS_NEXT;
                end
                else if (fill_reg == FILL_W'(1))
                begin
                    state_next = S_RS_PLACE;
                end
                else
                begin
                    state_next = S_RS_TGT_RD;
                end
            end
            // Look for the tag among the entries already copied.
            S_RS_TGT_RD:
            begin
                mem_ra     = addr_of(tgt_reg, jslot_reg);
                state_next = S_RS_TGT_CHK;
            end
            S_RS_TGT_CHK:
            begin
                if (rdata_reg[FIELD_W-1:0] == word_reg[FIELD_W-1:0])
                begin
                    state_next = S_RS_NEXT;
                end
                else if (FILL_W'(jslot_reg) + 1'b1 == fill_reg)
                begin
                    state_next = S_RS_PLACE;
                end
                else
                begin
                    jslot_next = jslot_reg + 1'b1;
                    state_next = S_RS_TGT_RD;
                end
            end
            S_RS_PLACE:
            begin
                if (fill_reg < FILL_W'(PAGE_SLOTS))
                begin
                    mem_we    = 1'b1;
                    mem_wa    = addr_of(tgt_reg, fill_reg[SLOT_W-1:0]);
                    mem_wd    = word_reg;
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_RS_NEXT;
            end
            S_RS_NEXT:
            begin
                if (slot_reg == SLOT_W'(1))
                begin
                    mark_pg_next = tgt_reg;
                    rescue_next  = 1'b1;
                    state_next   = S_MK_RD;
                end
                else
                begin
                    slot_next  = slot_reg - 1'b1;
                    state_next = S_RS_SRC_RD;
                end
            end
            // Mark a page current: keep the high halfword of its marker slot.
            S_MK_RD:
            begin
                mem_ra     = addr_of(mark_pg_reg, '0);
                state_next = S_MK_WR;
            end
            S_MK_WR:
            begin
                mem_we    = 1'b1;
                mem_wa    = addr_of(mark_pg_reg, '0);
                mem_wd    = {rdata_reg[WORD_W-1:FIELD_W], marker_reg};
                slot_next = '0;
                if (rescue_reg)
                begin
                    state_next = S_RE_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Erase the old page after a rescue.
            S_RE_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wa    = addr_of(cur_reg, slot_reg);
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            // Hand the response to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An accepted request always starts with the page search.
    a_accept_find: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_FIND_RD)
        else $error("request accepted without starting the page search");

    // A response whose status is not OK carries zero data.
    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.read_data == '0)
        else $error("failed response carries data");

    // The fill count of a rescue never runs past the page.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RS_PLACE |-> fill_reg <= FILL_W'(PAGE_SLOTS) && fill_reg != '0)
        else $error("rescue fill count out of range");

    // No status code outside the defined three is ever sent.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_NOT_FOUND
                      || rsp.status == ST_NO_PAGE)
        else $error("undefined response status");

endmodule
